[rtl/core/e2c_pkg.sv]
// Package for the epoch seconds to calendar converter.
// Holds constants, datapath op codes, controller/datapath structs and a helper function.
// No dependencies.
package e2c_pkg;

    localparam int unsigned SECS_W   = 31;
    localparam int unsigned DAYS_W   = 15;
    localparam int unsigned YEAR_W   = 8;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned MDAY_W   = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MIN_W    = 6;
    localparam int unsigned SEC_W    = 6;
    localparam int unsigned WDAY_W   = 3;
    localparam int unsigned YDAY_W   = 9;
    localparam int unsigned STEP_W   = 1;

    localparam logic [SECS_W-1:0] SECS_PER_DAY  = 31'd86400;
    localparam logic [SECS_W-1:0] SECS_PER_HOUR = 31'd3600;
    localparam logic [SECS_W-1:0] SECS_PER_MIN  = 31'd60;
    localparam logic [SECS_W-1:0] DAYS_PER_WEEK = 31'd7;

    localparam logic [YEAR_W-1:0] BASE_YEAR_OFS = 8'd70;   // 1970 - 1900
    localparam logic [WDAY_W:0]   EPOCH_WDAY    = 4'd4;    // Thursday
    localparam logic [WDAY_W:0]   WEEK_LEN      = 4'd7;
    localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd11;
    localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd1;

    // constant divides: x / d = ((x >> pre) * ceil(2^s / (d >> pre))) >> s,
    // exact over the operand range of each divide
    localparam int unsigned MUL_A_W = 24;
    localparam int unsigned MUL_B_W = 25;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    localparam int unsigned        DAY_PRE    = 7;     // 86400 = 675 << 7
    localparam int unsigned        DAY_SHIFT  = 34;
    localparam logic [MUL_B_W-1:0] DAY_RECIP  = 25'd25451659;
    localparam int unsigned        HOUR_PRE   = 4;     // 3600 = 225 << 4
    localparam int unsigned        HOUR_SHIFT = 21;
    localparam logic [MUL_B_W-1:0] HOUR_RECIP = 25'd9321;
    localparam int unsigned        MIN_PRE    = 2;     // 60 = 15 << 2
    localparam int unsigned        MIN_SHIFT  = 14;
    localparam logic [MUL_B_W-1:0] MIN_RECIP  = 25'd1093;
    localparam int unsigned        WDAY_SHIFT = 18;
    localparam logic [MUL_B_W-1:0] WDAY_RECIP = 25'd37450;

    // datapath op codes
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LOAD     = 4'd1;
    localparam logic [3:0] OP_DIV_DAY  = 4'd2;
    localparam logic [3:0] OP_DIV_HOUR = 4'd3;
    localparam logic [3:0] OP_DIV_MIN  = 4'd4;
    localparam logic [3:0] OP_DIV_WDAY = 4'd5;
    localparam logic [3:0] OP_YEAR     = 4'd6;
    localparam logic [3:0] OP_MONTH    = 4'd7;
    localparam logic [3:0] OP_FIN      = 4'd8;

    typedef struct packed {
        logic [3:0]        op;
        logic [STEP_W-1:0] k;
    } e2c_cmd_t;

    typedef struct packed {
        logic year_fit;
        logic month_fit;
        logic out_free;
    } e2c_status_t;

    function automatic logic [MDAY_W:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
        logic [MDAY_W:0] len;
        unique case (month)
            FEBRUARY:                    len = leap ? 6'd29 : 6'd28;
            4'd3, 4'd5, 4'd8, 4'd10:     len = 6'd30;
            default:                     len = 6'd31;
        endcase
        return len;
    endfunction

endpackage

[rtl/core/e2c_in_if.sv]
// Input channel: one beat carries a seconds count since 1970.
// Depends on e2c_pkg.
interface e2c_in_if
    import e2c_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SECS_W-1:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

[rtl/core/e2c_out_if.sv]
// Output channel: one beat carries a broken-down calendar time.
// Depends on e2c_pkg.
interface e2c_out_if
    import e2c_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  years_since_1900;
    logic [MONTH_W-1:0] month_index;
    logic [MDAY_W-1:0]  day_of_month;
    logic [HOUR_W-1:0]  hour_of_day;
    logic [MIN_W-1:0]   minute_of_hour;
    logic [SEC_W-1:0]   second_of_minute;
    logic [WDAY_W-1:0]  weekday;
    logic [YDAY_W-1:0]  day_of_year;

    modport source (output valid, output years_since_1900, output month_index,
                    output day_of_month, output hour_of_day, output minute_of_hour,
                    output second_of_minute, output weekday, output day_of_year,
                    input ready);
    modport sink   (input valid, input years_since_1900, input month_index,
                    input day_of_month, input hour_of_day, input minute_of_hour,
                    input second_of_minute, input weekday, input day_of_year,
                    output ready);
endinterface

[rtl/core/e2c_datapath.sv]
// Datapath: shared reciprocal multiply for the constant divides, year and month
// subtract loops, output register. Depends on e2c_pkg and e2c_out_if.
module e2c_datapath
    import e2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SECS_W-1:0] epoch_seconds,
    input  e2c_cmd_t          cmd,
    output e2c_status_t       status,
    e2c_out_if.source         calendar
);

    logic [SECS_W-1:0]  rem_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DAYS_W-1:0]  days_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [MIN_W-1:0]   minute_reg;
    logic [SEC_W-1:0]   second_reg;
    logic [WDAY_W-1:0]  wday_reg;
    logic [YEAR_W-1:0]  year_reg;
    logic [YDAY_W-1:0]  yday_reg;
    logic [MONTH_W-1:0] month_reg;
    logic               leap_reg;
    logic               out_valid_reg;

    logic [YEAR_W-1:0]  o_year_reg;
    logic [MONTH_W-1:0] o_month_reg;
    logic [MDAY_W-1:0]  o_mday_reg;
    logic [HOUR_W-1:0]  o_hour_reg;
    logic [MIN_W-1:0]   o_minute_reg;
    logic [SEC_W-1:0]   o_second_reg;
    logic [WDAY_W-1:0]  o_wday_reg;
    logic [YDAY_W-1:0]  o_yday_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_next;
    logic [DAYS_W-1:0]  quo;
    logic [SECS_W-1:0]  divisor;
    logic [SECS_W-1:0]  rem_next;
    logic [WDAY_W:0]    wsum;
    logic [WDAY_W-1:0]  wday_next;
    logic [YDAY_W-1:0]  ylen;
    logic [MDAY_W:0]    mlen;
    logic               last_step;

    always_comb
    begin
        unique case (cmd.op)
            OP_DIV_DAY:
            begin
                mul_a   = MUL_A_W'(rem_reg >> DAY_PRE);
                mul_b   = DAY_RECIP;
                quo     = DAYS_W'(prod_reg >> DAY_SHIFT);
                divisor = SECS_PER_DAY;
            end
            OP_DIV_HOUR:
            begin
                mul_a   = MUL_A_W'(rem_reg >> HOUR_PRE);
                mul_b   = HOUR_RECIP;
                quo     = DAYS_W'(prod_reg >> HOUR_SHIFT);
                divisor = SECS_PER_HOUR;
            end
            OP_DIV_MIN:
            begin
                mul_a   = MUL_A_W'(rem_reg >> MIN_PRE);
                mul_b   = MIN_RECIP;
                quo     = DAYS_W'(prod_reg >> MIN_SHIFT);
                divisor = SECS_PER_MIN;
            end
            OP_DIV_WDAY:
            begin
                mul_a   = MUL_A_W'(rem_reg);
                mul_b   = WDAY_RECIP;
                quo     = DAYS_W'(prod_reg >> WDAY_SHIFT);
                divisor = DAYS_PER_WEEK;
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                quo     = '0;
                divisor = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
        rem_next  = rem_reg - (SECS_W'(quo) * divisor);
        last_step = cmd.k == '0;
        wsum      = {1'b0, rem_next[WDAY_W-1:0]} + EPOCH_WDAY;
        wday_next = (wsum >= WEEK_LEN) ? WDAY_W'(wsum - WEEK_LEN) : wsum[WDAY_W-1:0];
        ylen      = (year_reg[1:0] == 2'd0) ? 9'd366 : 9'd365;
        mlen      = month_len(month_reg, leap_reg);
    end

    assign status.year_fit  = days_reg < DAYS_W'(ylen);
    assign status.month_fit = (month_reg == LAST_MONTH) || (days_reg < DAYS_W'(mlen));
    assign status.out_free  = !out_valid_reg || calendar.ready;

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                rem_reg  <= epoch_seconds;
                year_reg <= BASE_YEAR_OFS;
            end
            OP_DIV_DAY:
            begin
                if (last_step)
                begin
                    days_reg <= quo;
                    rem_reg  <= rem_next;
                end
                else
                begin
                    prod_reg <= prod_next;
                end
            end
            OP_DIV_HOUR:
            begin
                if (last_step)
                begin
                    hour_reg <= quo[HOUR_W-1:0];
                    rem_reg  <= rem_next;
                end
                else
                begin
                    prod_reg <= prod_next;
                end
            end
            OP_DIV_MIN:
            begin
                if (last_step)
                begin
                    minute_reg <= quo[MIN_W-1:0];
                    second_reg <= rem_next[SEC_W-1:0];
                    rem_reg    <= SECS_W'(days_reg);
                end
                else
                begin
                    prod_reg <= prod_next;
                end
            end
            OP_DIV_WDAY:
            begin
                if (last_step)
                begin
                    wday_reg <= wday_next;
                end
                else
                begin
                    prod_reg <= prod_next;
                end
            end
            OP_YEAR:
            begin
                if (status.year_fit)
                begin
                    yday_reg  <= days_reg[YDAY_W-1:0];
                    month_reg <= '0;
                    leap_reg  <= year_reg[1:0] == 2'd0;
                end
                else
                begin
                    days_reg <= days_reg - DAYS_W'(ylen);
                    year_reg <= year_reg + 8'd1;
                end
            end
            OP_MONTH:
            begin
                if (!status.month_fit)
                begin
                    days_reg  <= days_reg - DAYS_W'(mlen);
                    month_reg <= month_reg + 4'd1;
                end
            end
            OP_FIN:
            begin
                o_year_reg   <= year_reg;
                o_month_reg  <= month_reg;
                o_mday_reg   <= days_reg[MDAY_W-1:0] + 5'd1;
                o_hour_reg   <= hour_reg;
                o_minute_reg <= minute_reg;
                o_second_reg <= second_reg;
                o_wday_reg   <= wday_reg;
                o_yday_reg   <= yday_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_FIN)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (calendar.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign calendar.valid            = out_valid_reg;
    assign calendar.years_since_1900 = o_year_reg;
    assign calendar.month_index      = o_month_reg;
    assign calendar.day_of_month     = o_mday_reg;
    assign calendar.hour_of_day      = o_hour_reg;
    assign calendar.minute_of_hour   = o_minute_reg;
    assign calendar.second_of_minute = o_second_reg;
    assign calendar.weekday          = o_wday_reg;
    assign calendar.day_of_year      = o_yday_reg;

`ifndef SYNTHESIS
    a_fin_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_FIN |-> status.out_free)
        else $error("result register overwritten while beat pending");
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_MONTH |-> month_reg <= LAST_MONTH && year_reg >= BASE_YEAR_OFS
                               && year_reg <= 8'd138)
        else $error("month or year out of range in month loop");
    a_out_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> o_wday_reg < 3'd7 && o_mday_reg != 5'd0)
        else $error("bad weekday or day of month on output");
`endif

endmodule

[rtl/core/e2c_ctrl.sv]
// Controller: sequences divide phases, year loop, month loop and result hand-off.
// Depends on e2c_pkg.
module e2c_ctrl
    import e2c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output e2c_cmd_t    cmd,
    input  e2c_status_t status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_YEAR  = 3'd2;
    localparam logic [2:0] S_MONTH = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // multiply cycle first, then quotient and remainder cycle
    localparam logic [STEP_W-1:0] K_DAY  = 1'b1;
    localparam logic [STEP_W-1:0] K_HOUR = 1'b1;
    localparam logic [STEP_W-1:0] K_MIN  = 1'b1;
    localparam logic [STEP_W-1:0] K_WDAY = 1'b1;

    logic [2:0]        state_reg, state_next;
    logic [3:0]        phase_reg, phase_next;
    logic [STEP_W-1:0] k_reg, k_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        cmd.op     = OP_NONE;
        cmd.k      = k_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DIV;
                    phase_next = OP_DIV_DAY;
                    k_next     = K_DAY;
                end
            end
            S_DIV:
            begin
                cmd.op = phase_reg;
                if (k_reg != '0)
                begin
                    k_next = k_reg - 1'b1;
                end
                else
                begin
                    priority case (phase_reg)
                        OP_DIV_DAY:
                        begin
                            phase_next = OP_DIV_HOUR;
                            k_next     = K_HOUR;
                        end
                        OP_DIV_HOUR:
                        begin
                            phase_next = OP_DIV_MIN;
                            k_next     = K_MIN;
                        end
                        OP_DIV_MIN:
                        begin
                            phase_next = OP_DIV_WDAY;
                            k_next     = K_WDAY;
                        end
                        default:
                        begin
                            state_next = S_YEAR;
                        end
                    endcase
                end
            end
            S_YEAR:
            begin
                cmd.op = OP_YEAR;
                if (status.year_fit)
                begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                cmd.op = OP_MONTH;
                if (status.month_fit)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= OP_DIV_DAY;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DIV && phase_reg == OP_DIV_DAY
                                 && k_reg == K_DAY)
        else $error("accepted beat did not start the day divide");
    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> (phase_reg == OP_DIV_DAY && k_reg <= K_DAY)
                               || (phase_reg == OP_DIV_HOUR && k_reg <= K_HOUR)
                               || (phase_reg == OP_DIV_MIN && k_reg <= K_MIN)
                               || (phase_reg == OP_DIV_WDAY && k_reg <= K_WDAY))
        else $error("divide step index out of range for phase");
    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && status.out_free |=> state_reg == S_IDLE)
        else $error("result hand-off did not return to idle");
`endif

endmodule

[rtl/core/epoch_seconds_to_calendar.sv]
// Epoch seconds to calendar time converter, top level.
// Channel "epoch" takes one beat of epoch_seconds (seconds since 1970-01-01 00:00:00,
// no time zone); channel "calendar" returns one beat of broken-down time per input.
// Both channels use valid/ready; a beat moves when both are high at a rising edge.
// One conversion at a time: epoch.ready is high only while the converter is idle.
// After the input beat is loaded, four constant divides (days, hours, minutes,
// weekday) each take a reciprocal multiply step, then a remainder step. Then the
// year loop subtracts whole years past 1970 (Y, 0..68) and the month loop whole
// months (month index M, 0..11), each loop with a closing step; Y + M is at most
// 78. Last, the result is loaded into the output register.
// The result sits in an output register; if calendar.ready is low the converter
// finishes its work and holds in its last step until the register frees up, and
// takes no new beat until then.
// Reset (rst_n, asynchronous, active low) returns the controller to idle and drops
// calendar.valid; no other state is kept between conversions.
// Depends on e2c_pkg, e2c_in_if, e2c_out_if, e2c_ctrl, e2c_datapath.
module epoch_seconds_to_calendar
    import e2c_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    e2c_in_if.sink    epoch,
    e2c_out_if.source calendar
);

    e2c_cmd_t    cmd;
    e2c_status_t status;
    logic        ctl_ready;

    assign epoch.ready = ctl_ready;

    e2c_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (epoch.valid),
        .in_ready (ctl_ready),
        .cmd      (cmd),
        .status   (status)
    );

    e2c_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .epoch_seconds (epoch.epoch_seconds),
        .cmd           (cmd),
        .status        (status),
        .calendar      (calendar)
    );

endmodule
